// ===== rtl/fenwick_range_sum_store_unit_macros.svh =====
// Assertion macros used by the checker of the range sum store.
// Needs nothing else; every macro samples on the rising clock edge.
`ifndef FENWICK_RANGE_SUM_STORE_UNIT_MACROS_SVH
`define FENWICK_RANGE_SUM_STORE_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define FRSS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FRSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/frss_pkg.sv =====
// Shared types, codes and field widths of the range sum store.
// No dependencies.
`default_nettype none

package frss_pkg;

  localparam int DEPTH_DEFAULT = 1024;

  localparam int CMD_W       = 2;
  localparam int IDX_W       = 10;
  localparam int END_W       = 11;
  localparam int VAL_W       = 64;
  localparam int IN_TDATA_W  = 88;  // IDX_W + END_W + VAL_W, padded to bytes
  localparam int OUT_TDATA_W = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_SET   = 2'd1,
    CMD_QUERY = 2'd2
  } frss_cmd_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_VS_WR,
    ST_TR_RD,
    ST_TR_WR,
    ST_Q_RD,
    ST_Q_ACC,
    ST_Q_OUT
  } frss_state_e;

  // controller -> datapath
  typedef struct packed {
    logic clr;
    logic load;
    logic vs_rd;
    logic vs_wr;
    logic tr_rd;
    logic tr_wr;
    logic q_rd;
    logic q_acc;
    logic q_switch;
    logic out_load;
  } frss_ctl_t;

  // datapath -> controller
  typedef struct packed {
    frss_cmd_e cmd;
    logic      upd_ok;
    logic      x_zero;
    logic      x_over;
    logic      phase;
    logic      clr_last;
    logic      out_free;
  } frss_sts_t;

endpackage

`default_nettype wire

// ===== rtl/fenwick_range_sum_store_unit.sv =====
// Range sum store over DEPTH signed 64-bit entries (binary indexed tree).
// Input requests on s_axis: tuser = command (add, set, range query);
// tdata = index, range_end, value. Add and set change state and return
// nothing; a query returns one result on m_axis with the wrapped sum of
// entries index .. range_end-1 (bounds clamped to DEPTH).
// Requests are taken one at a time; s_axis_tready is high only when idle.
// Steps, with n = number of tree nodes visited (at most log2(DEPTH)+1):
//   add/set : value RAM read and write, then one read and one write of the tree
//             RAM per node.
//   query   : a walk over n_hi, then one over n_lo nodes into the accumulator,
//             then a load of the result register; n_hi and n_lo are the set bits
//             of the clamped bounds (each at most log2(DEPTH)); each node costs
//             one tree RAM read plus an accumulate step. Ready returns with that load.
// After reset both RAMs are cleared, one entry per cycle, with
// s_axis_tready low. A query result waits in an output register; the next
// request is accepted meanwhile, and only a second query stalls at its end
// until the pending result is taken.
// Depends on frss_pkg, frss_ctrl, frss_dp, frss_ram.
`default_nettype none

module fenwick_range_sum_store_unit #(
  parameter int DEPTH = frss_pkg::DEPTH_DEFAULT
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // slave side: requests
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [9:0] index, [20:10] range_end, [84:21] value, [87:85] zero
  input  wire logic [frss_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] command
  input  wire logic [frss_pkg::CMD_W-1:0]       s_axis_tuser,
  // master side: query results
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [63:0] range_sum
  output logic      [frss_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  frss_pkg::frss_ctl_t ctl;
  frss_pkg::frss_sts_t sts;

  // sequencer: clearing pass, update and query walks
  frss_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .ctl_o     (ctl)
  );

  // datapath: request regs, tree/value RAMs, accumulator, result register
  frss_dp #(.DEPTH(DEPTH)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (s_axis_tdata),
    .in_cmd_i   (s_axis_tuser),
    .out_data_o (m_axis_tdata),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .ctl_i      (ctl),
    .sts_o      (sts)
  );

endmodule

`default_nettype wire

// ===== rtl/frss_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module frss_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/frss_ctrl.sv =====
// Sequencer of the range sum store: clearing pass, update walk, query walks.
// Depends on frss_pkg.
`default_nettype none

module frss_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire frss_pkg::frss_sts_t sts_i,
  output frss_pkg::frss_ctl_t      ctl_o
);

  frss_pkg::frss_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frss_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      frss_pkg::ST_CLEAR: begin
        ctl_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = frss_pkg::ST_IDLE;
        end
      end
      frss_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = frss_pkg::ST_DECODE;
        end
      end
      frss_pkg::ST_DECODE: begin
        unique case (sts_i.cmd)
          frss_pkg::CMD_ADD, frss_pkg::CMD_SET: begin
            if (sts_i.upd_ok) begin
              ctl_o.vs_rd = 1'b1;
              state_d     = frss_pkg::ST_VS_WR;
            end else begin
              state_d = frss_pkg::ST_IDLE;
            end
          end
          frss_pkg::CMD_QUERY: state_d = frss_pkg::ST_Q_RD;
          default:             state_d = frss_pkg::ST_IDLE;
        endcase
      end
      frss_pkg::ST_VS_WR: begin
        ctl_o.vs_wr = 1'b1;
        state_d     = frss_pkg::ST_TR_RD;
      end
      frss_pkg::ST_TR_RD: begin
        if (sts_i.x_over) begin
          state_d = frss_pkg::ST_IDLE;
        end else begin
          ctl_o.tr_rd = 1'b1;
          state_d     = frss_pkg::ST_TR_WR;
        end
      end
      frss_pkg::ST_TR_WR: begin
        ctl_o.tr_wr = 1'b1;
        state_d     = frss_pkg::ST_TR_RD;
      end
      frss_pkg::ST_Q_RD: begin
        priority if (!sts_i.x_zero) begin
          ctl_o.q_rd = 1'b1;
          state_d    = frss_pkg::ST_Q_ACC;
        end else if (!sts_i.phase) begin
          ctl_o.q_switch = 1'b1;  // second walk from lo
        end else begin
          state_d = frss_pkg::ST_Q_OUT;
        end
      end
      frss_pkg::ST_Q_ACC: begin
        ctl_o.q_acc = 1'b1;
        state_d     = frss_pkg::ST_Q_RD;
      end
      frss_pkg::ST_Q_OUT: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          state_d        = frss_pkg::ST_IDLE;
        end
      end
      default: state_d = frss_pkg::ST_CLEAR;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/frss_dp.sv =====
// Datapath of the range sum store: request registers, walk index,
// accumulator, output register and the two RAMs.
// Depends on frss_pkg and frss_ram.
`default_nettype none

module frss_dp #(
  parameter int DEPTH = frss_pkg::DEPTH_DEFAULT
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic [frss_pkg::IN_TDATA_W-1:0]    in_data_i,
  input  wire logic [frss_pkg::CMD_W-1:0]         in_cmd_i,
  output logic      [frss_pkg::OUT_TDATA_W-1:0]   out_data_o,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  input  wire frss_pkg::frss_ctl_t                ctl_i,
  output frss_pkg::frss_sts_t                     sts_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int XW = (AW + 2 > 12) ? AW + 2 : 12;
  localparam int VW = frss_pkg::VAL_W;
  localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  logic [frss_pkg::IDX_W-1:0] in_index;
  logic [frss_pkg::END_W-1:0] in_end;
  logic signed [VW-1:0]       in_value;
  logic [XW-1:0]              idx_x, end_x, lo_c, hi_c;
  frss_pkg::frss_cmd_e        in_cmd;

  assign in_index = in_data_i[frss_pkg::IDX_W-1:0];
  assign in_end   = in_data_i[frss_pkg::IDX_W +: frss_pkg::END_W];
  assign in_value = in_data_i[frss_pkg::IDX_W + frss_pkg::END_W +: VW];
  assign in_cmd   = frss_pkg::frss_cmd_e'(in_cmd_i);
  assign idx_x    = XW'(in_index);
  assign end_x    = XW'(in_end);
  assign lo_c     = (idx_x > DEPTH_X) ? DEPTH_X : idx_x;
  assign hi_c     = (end_x > DEPTH_X) ? DEPTH_X : end_x;

  frss_pkg::frss_cmd_e  cmd_q;
  logic                 upd_ok_q;
  logic [AW-1:0]        idx_a_q;
  logic [XW-1:0]        lo_q, x_q, x_m1;
  logic signed [VW-1:0] val_q, delta_q, acc_q, out_q;
  logic                 phase_q, out_valid_q;
  logic [AW-1:0]        cnt_q;

  logic signed [VW-1:0] vs_rdata, tr_rdata, vs_wdata, tr_wdata;
  logic [AW-1:0]        vs_waddr, tr_waddr, tr_addr;

  assign x_m1    = x_q - XW'(1);
  assign tr_addr = x_m1[AW-1:0];

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.clr) begin
        cnt_q <= cnt_q + AW'(1);
      end
      if (ctl_i.load) begin
        phase_q <= 1'b0;
      end else if (ctl_i.q_switch) begin
        phase_q <= 1'b1;
      end
      if (ctl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q    <= in_cmd;
      upd_ok_q <= idx_x < DEPTH_X;
      idx_a_q  <= idx_x[AW-1:0];
      lo_q     <= lo_c;
      val_q    <= in_value;
      acc_q    <= '0;
      x_q      <= (in_cmd == frss_pkg::CMD_QUERY) ? hi_c : idx_x + XW'(1);
    end
    if (ctl_i.vs_wr) begin
      delta_q <= (cmd_q == frss_pkg::CMD_SET) ? val_q - vs_rdata : val_q;
    end
    if (ctl_i.tr_wr) begin
      x_q <= x_q + (x_q & (~x_q + XW'(1)));  // climb to next covering node
    end
    if (ctl_i.q_acc) begin
      x_q   <= x_q & x_m1;                   // drop lowest set bit
      acc_q <= phase_q ? acc_q - tr_rdata : acc_q + tr_rdata;
    end
    if (ctl_i.q_switch) begin
      x_q <= lo_q;
    end
    if (ctl_i.out_load) begin
      out_q <= acc_q;
    end
  end

  assign vs_waddr = ctl_i.clr ? cnt_q : idx_a_q;
  assign vs_wdata = ctl_i.clr ? '0 :
                    (cmd_q == frss_pkg::CMD_SET) ? val_q : vs_rdata + val_q;
  assign tr_waddr = ctl_i.clr ? cnt_q : tr_addr;
  assign tr_wdata = ctl_i.clr ? '0 : tr_rdata + delta_q;

  frss_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (ctl_i.clr | ctl_i.vs_wr),
    .waddr_i(vs_waddr),
    .wdata_i(vs_wdata),
    .re_i   (ctl_i.vs_rd),
    .raddr_i(idx_a_q),
    .rdata_o(vs_rdata)
  );

  frss_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_tree_ram (
    .clk_i  (clk_i),
    .we_i   (ctl_i.clr | ctl_i.tr_wr),
    .waddr_i(tr_waddr),
    .wdata_i(tr_wdata),
    .re_i   (ctl_i.tr_rd | ctl_i.q_rd),
    .raddr_i(tr_addr),
    .rdata_o(tr_rdata)
  );

  assign sts_o.cmd      = cmd_q;
  assign sts_o.upd_ok   = upd_ok_q;
  assign sts_o.x_zero   = (x_q == '0);
  assign sts_o.x_over   = (x_q > DEPTH_X);
  assign sts_o.phase    = phase_q;
  assign sts_o.clr_last = (cnt_q == LAST_A);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/frss_checker.sv =====
// Port-level checks of the range sum store, bound to the top level.
// Depends on frss_pkg and the assertion macro header.
`default_nettype none
`include "fenwick_range_sum_store_unit_macros.svh"

module frss_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [frss_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic in_fire;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  // one request in flight: ready drops right after an accept
  `FRSS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_fire, !s_axis_tready, "ready after accept")
  // a result is loaded only while the input side is busy
  `FRSS_ASSERT_NOW(a_result_while_busy, clk_i, rst_ni, $rose(m_axis_tvalid), $past(!s_axis_tready), "result while idle")
  `FRSS_ASSERT_NEXT(a_valid_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "valid dropped")
  `FRSS_ASSERT_NEXT(a_data_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "data changed")

endmodule

bind fenwick_range_sum_store_unit frss_checker u_frss_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for fenwick_range_sum_store_unit: directed and random
// add/set/query and unused-command requests, results checked against an in-bench binary indexed tree.
// Depends on frss_pkg and the RTL of the range sum store.
`timescale 1ns / 1ps

module testbench;
  import frss_pkg::*;

  localparam int TREE_DEPTH = DEPTH_DEFAULT;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_REQS = 1830;
  localparam int TAIL_REQS = 150;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;

  localparam logic [63:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN_NEG = 64'h8000_0000_0000_0000;

  // Expected-sum tracker: mirrors the tree and the per-entry value copy.
  class range_sum_board;
    bit [63:0] tree_nodes[TREE_DEPTH];
    bit [63:0] entry_values[TREE_DEPTH];
    bit [63:0] pending_sums[$];
    int        mismatches;
    int        sums_checked;
    int        n_add, n_set, n_query, n_unused;

    function new();
      foreach (tree_nodes[i]) begin
        tree_nodes[i] = '0;
        entry_values[i] = '0;
      end
      mismatches = 0;
      sums_checked = 0;
      n_add = 0;
      n_set = 0;
      n_query = 0;
      n_unused = 0;
    endfunction

    function void tree_bump(int unsigned pos, bit [63:0] delta);
      int unsigned x;
      x = pos + 1;
      while (x <= TREE_DEPTH) begin
        tree_nodes[x-1] += delta;
        x += x & (~x + 1);
      end
    endfunction

    function bit [63:0] prefix_sum(int unsigned n);
      bit [63:0]   total;
      int unsigned x;
      total = '0;
      x = n;
      while (x != 0) begin
        total += tree_nodes[x-1];
        x &= x - 1;
      end
      return total;
    endfunction

    // Called once per accepted request.
    function void note_request(logic [CMD_W-1:0] cmd, int unsigned idx,
                               int unsigned hi, bit [63:0] val);
      int unsigned lo;
      case (cmd)
        CMD_ADD: begin
          n_add++;
          if (idx < TREE_DEPTH) begin
            tree_bump(idx, val);
            entry_values[idx] += val;
          end
        end
        CMD_SET: begin
          n_set++;
          if (idx < TREE_DEPTH) begin
            tree_bump(idx, val - entry_values[idx]);
            entry_values[idx] = val;
          end
        end
        CMD_QUERY: begin
          n_query++;
          lo = (idx > TREE_DEPTH) ? TREE_DEPTH : idx;
          if (hi > TREE_DEPTH) hi = TREE_DEPTH;
          pending_sums.insert(pending_sums.size(), prefix_sum(hi) - prefix_sum(lo));
        end
        default: n_unused++;
      endcase
    endfunction

    function void check_sum(bit [63:0] got);
      bit [63:0] want;
      if (pending_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected range sum %h, nothing pending", $time, got);
        return;
      end
      want = pending_sums.pop_front();
      sums_checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] range_sum mismatch: expected %h, got %h", $time, want, got);
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [CMD_W-1:0]       s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  range_sum_board board = new();

  int sent_count = 0;
  bit steady_tail = 1'b0;
  bit hold_off_req = 1'b0;
  bit hold_off_seen = 1'b0;

  always #4 clk_i = ~clk_i;

  fenwick_range_sum_store_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Offer one request, wait for the handshake, then maybe leave a gap.
  task automatic send_request(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                              logic [END_W-1:0] hi, logic [63:0] val);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {3'b000, val, hi, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_request(cmd, idx, hi, val);
    sent_count++;
    // quiet windows of 40 requests every 200, plus no gaps in the tail
    if (!steady_tail && (sent_count % 200) >= 40 && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 5);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 9))
      0: return MAX_POS;
      1: return MIN_NEG;
      2: return 64'hFFFF_FFFF_FFFF_FFFF;
      3, 4, 5: return 64'(signed'($urandom_range(0, 2000)) - 1000);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(0, 3) == 0) return IDX_W'($urandom_range(0, 15));
    return IDX_W'($urandom_range(0, TREE_DEPTH - 1));
  endfunction

  task automatic send_random_request();
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] idx;
    logic [END_W-1:0] hi;
    int               sel;
    sel = $urandom_range(0, 99);
    if (sel < 30)      cmd = CMD_ADD;
    else if (sel < 55) cmd = CMD_SET;
    else if (sel < 93) cmd = CMD_QUERY;
    else               cmd = CMD_UNUSED;
    idx = pick_index();
    case ($urandom_range(0, 6))
      0:       hi = END_W'($urandom_range(TREE_DEPTH + 1, 2047));
      1:       hi = END_W'(idx + $urandom_range(0, 20));
      2:       hi = END_W'($urandom_range(0, 16));
      default: hi = END_W'($urandom_range(0, TREE_DEPTH));
    endcase
    send_request(cmd, idx, hi, pick_value());
  endtask

  // Result side: random stall bursts, one long hold-off on request.
  initial begin
    int  hold_cnt;
    bit  quiet;
    hold_cnt = 0;
    quiet = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) board.check_sum(m_axis_tdata);
      if ($urandom_range(0, 63) == 0) quiet = ~quiet;
      if (hold_off_req && !hold_off_seen) begin
        hold_off_seen = 1'b1;
        hold_cnt = HOLD_OFF_CYCLES;
      end else if (hold_cnt == 0 && !steady_tail && !quiet && $urandom_range(0, 4) == 0) begin
        hold_cnt = $urandom_range(1, 5);
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    #6ms;
    $display("timeout: %0d range sums still pending", board.pending_sums.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int real_reqs;
    real_reqs = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, every command, clamping, reversed and empty ranges
    send_request(CMD_QUERY, 10'd0, 11'd1024, '0);
    send_request(CMD_ADD, 10'd0, 11'd0, MAX_POS);
    send_request(CMD_ADD, 10'd1023, 11'd2047, MIN_NEG);
    send_request(CMD_ADD, 10'd512, 11'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(CMD_QUERY, 10'd0, 11'd1024, '0);
    send_request(CMD_QUERY, 10'd0, 11'd2047, '0);
    send_request(CMD_SET, 10'd0, 11'd0, 64'h5555_5555_5555_5555);
    send_request(CMD_SET, 10'd1023, 11'd0, 64'hAAAA_AAAA_AAAA_AAAA);
    // add then set: set must see the copy updated by the add
    send_request(CMD_ADD, 10'd0, 11'd0, 64'd1);
    send_request(CMD_QUERY, 10'd0, 11'd1, '0);
    send_request(CMD_SET, 10'd0, 11'd0, 64'd0);
    send_request(CMD_QUERY, 10'd1023, 11'd1024, '0);
    send_request(CMD_QUERY, 10'd1023, 11'd5, '0);
    send_request(CMD_QUERY, 10'd5, 11'd5, '0);
    send_request(CMD_QUERY, 10'd0, 11'd0, '0);
    send_request(CMD_UNUSED, 10'd7, 11'd100, 64'h0123_4567_89AB_CDEF);
    send_request(CMD_QUERY, 10'd0, 11'd1024, '0);
    send_request(CMD_ADD, 10'd341, 11'd1365, 64'd1);
    send_request(CMD_ADD, 10'd682, 11'd682, 64'd2);
    send_request(CMD_QUERY, 10'd682, 11'd1366, '0);
    send_request(CMD_QUERY, 10'd341, 11'd683, '0);
    send_request(CMD_SET, 10'd1023, 11'd2047, 64'd0);
    send_request(CMD_QUERY, 10'd0, 11'd1024, '0);

    while (real_reqs < RANDOM_REQS) begin
      if (real_reqs == 300) hold_off_req = 1'b1;
      if (real_reqs >= RANDOM_REQS - TAIL_REQS) steady_tail = 1'b1;
      send_random_request();
      real_reqs++;
    end
    s_axis_tvalid <= 1'b0;

    while (board.pending_sums.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d add, %0d set, %0d query and %0d unused-command requests;",
             board.n_add, board.n_set, board.n_query, board.n_unused);
    $display("%0d range sums compared, %0d mismatches, %0d left pending.",
             board.sums_checked, board.mismatches, board.pending_sums.size());
    if (board.mismatches == 0 && board.pending_sums.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
